FILE: src/jekm_pkg.sv
`default_nettype none

package jekm_pkg;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_EVENT     = 2'd0,
    REQ_BTN_WRITE = 2'd1,
    REQ_AX_WRITE  = 2'd2
  } req_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUTTONS_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AXES_IN_USE    = 1'b1;

  // at most this many keys per event
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned RESULT_CNT_W = 5;

  // compare width that holds any control number and any count up to 256
  localparam int unsigned NUM_CMP_W = 9;

  // button table slot, enable kept apart in flops
  typedef struct packed {
    logic [7:0] button;
    logic       chord_en;
    logic [7:0] chord;
    logic [7:0] key;
  } btn_entry_t;

  // axis table slot, enable kept apart in flops
  typedef struct packed {
    logic [7:0]         axis;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [7:0]         key;
  } ax_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write_btn;
    logic write_ax;
    logic btn_update;
    logic ax_write;
    logic scan_start;
    logic issue;
    logic eval_chord;
    logic eval_plain;
    logic eval_move;
    logic flush;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       ev_init;
    logic       ev_axis;
    logic       in_range;
    logic       release_cond;
    logic       chord_hit;
    logic       issued_all;
    logic       rd_valid;
  } ctrl_status_t;

endpackage

`default_nettype wire

FILE: src/jekm_ram.sv
`default_nettype none

module jekm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/jekm_ctrl.sv
`default_nettype none

module jekm_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire jekm_pkg::ctrl_status_t  st,
  output jekm_pkg::ctrl_cmd_t          cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_CHORD  = 6'b000100,
    S_PLAIN  = 6'b001000,
    S_MOVE   = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   scan_done;

  // every issued read has been evaluated
  assign scan_done = st.issued_all && !st.rd_valid;
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (st.req_type)
          jekm_pkg::REQ_BTN_WRITE: begin
            cmd.write_btn = 1'b1;
          end
          jekm_pkg::REQ_AX_WRITE: begin
            cmd.write_ax = 1'b1;
          end
          jekm_pkg::REQ_EVENT: begin
            if (st.in_range) begin
              if (st.ev_axis) begin
                if (st.ev_init) begin
                  cmd.ax_write = 1'b1;
                end else begin
                  cmd.scan_start = 1'b1;
                  state_next     = S_MOVE;
                end
              end else if (st.release_cond) begin
                cmd.scan_start = 1'b1;
                state_next     = S_CHORD;
              end else begin
                cmd.btn_update = 1'b1;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_CHORD: begin
        cmd.eval_chord = 1'b1;
        if (st.chord_hit) begin
          state_next = S_FLUSH;
        end else if (scan_done) begin
          cmd.scan_start = 1'b1;
          state_next     = S_PLAIN;
        end else begin
          cmd.issue = !st.issued_all;
        end
      end
      S_PLAIN: begin
        cmd.eval_plain = 1'b1;
        cmd.issue      = !st.issued_all;
        if (scan_done) begin
          state_next = S_FLUSH;
        end
      end
      S_MOVE: begin
        cmd.eval_move = 1'b1;
        cmd.issue     = !st.issued_all;
        if (scan_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (st.ev_axis) begin
          cmd.ax_write = 1'b1;
        end else begin
          cmd.btn_update = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/jekm_dpath.sv
`default_nettype none

module jekm_dpath #(
  parameter int unsigned MAX_BUTTONS = 32,
  parameter int unsigned MAX_AXES    = 8,
  parameter int unsigned MAP_ENTRIES = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire jekm_pkg::ctrl_cmd_t                  cmd,
  output jekm_pkg::ctrl_status_t                    st,
  input  wire logic                                 cfg_we,
  input  wire logic [jekm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [jekm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic [1:0]                           req_type,
  input  wire logic                                 event_init,
  input  wire logic                                 event_axis,
  input  wire logic [7:0]                           control_number,
  input  wire logic signed [15:0]                   control_value,
  input  wire logic [3:0]                           entry_index,
  input  wire logic                                 entry_enable,
  input  wire logic                                 chord_enable,
  input  wire logic [7:0]                           chord_button,
  input  wire logic signed [15:0]                   range_low,
  input  wire logic signed [15:0]                   range_high,
  input  wire logic [7:0]                           entry_key,
  output logic                                      strobe,
  output logic [7:0]                                key_code,
  output logic [3:0]                                hit_entry,
  output logic                                      hit_is_axis,
  output logic                                      last_key
);

  localparam int unsigned BW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int unsigned AW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int unsigned EW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int unsigned NW = jekm_pkg::NUM_CMP_W;
  localparam logic [EW-1:0] LAST_IDX = EW'(MAP_ENTRIES - 1);

  // configuration registers
  logic [5:0] buttons_in_use;
  logic [3:0] axes_in_use;

  // item registers
  logic [1:0]         req_q;
  logic               init_q;
  logic               axis_q;
  logic [7:0]         num_q;
  logic signed [15:0] val_q;
  logic [3:0]         slot_q;
  logic               en_q;
  logic               chord_en_q;
  logic [7:0]         chord_q;
  logic signed [15:0] lo_q;
  logic signed [15:0] hi_q;
  logic [7:0]         key_q;

  // control state
  logic [MAX_BUTTONS-1:0] button_pressed;
  logic [MAX_AXES-1:0]    pos_valid;
  logic [MAP_ENTRIES-1:0] btn_en;
  logic [MAP_ENTRIES-1:0] ax_en;

  // scan
  logic [EW-1:0] scan_idx;
  logic [EW-1:0] rd_idx;
  logic          rd_valid;
  logic          issued_all;

  // pending result and count
  logic                              pend_valid;
  logic [7:0]                        pend_key;
  logic [3:0]                        pend_idx;
  logic                              pend_axis;
  logic [jekm_pkg::RESULT_CNT_W-1:0] hit_count;

  // memory ports
  logic [$bits(jekm_pkg::btn_entry_t)-1:0] btn_rdata;
  logic [$bits(jekm_pkg::ax_entry_t)-1:0]  ax_rdata;
  logic signed [15:0]                      pos_rdata;
  jekm_pkg::btn_entry_t                    btn_wr;
  jekm_pkg::ax_entry_t                     ax_wr;
  jekm_pkg::btn_entry_t                    btn_rd;
  jekm_pkg::ax_entry_t                     ax_rd;

  logic [BW-1:0]      btn_sel;
  logic [AW-1:0]      ax_sel;
  logic [EW-1:0]      slot_sel;
  logic               slot_ok;
  logic               num_in_buttons;
  logic               num_in_axes;
  logic signed [15:0] old_pos;
  logic               btn_base;
  logic               chord_held;
  logic               chord_match;
  logic               plain_match;
  logic               move_match;
  logic               hit_take;
  logic [7:0]         new_key;

  assign btn_sel  = num_q[BW-1:0];
  assign ax_sel   = num_q[AW-1:0];
  assign slot_sel = EW'(slot_q);
  assign slot_ok  = (7'(slot_q) < 7'(MAP_ENTRIES));

  // number checks against the clamped counts
  assign num_in_buttons = (NW'(num_q) < NW'(buttons_in_use)) &&
                          (NW'(num_q) < NW'(MAX_BUTTONS));
  assign num_in_axes    = (NW'(num_q) < NW'(axes_in_use)) &&
                          (NW'(num_q) < NW'(MAX_AXES));

  // configuration beats
  always_ff @(posedge clk) begin
    if (rst) begin
      buttons_in_use <= '0;
      axes_in_use    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jekm_pkg::CFG_BUTTONS_IN_USE: buttons_in_use <= cfg_data;
        jekm_pkg::CFG_AXES_IN_USE:    axes_in_use    <= cfg_data[3:0];
        default: begin
          buttons_in_use <= buttons_in_use;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q      <= req_type;
      init_q     <= event_init;
      axis_q     <= event_axis;
      num_q      <= control_number;
      val_q      <= control_value;
      slot_q     <= entry_index;
      en_q       <= entry_enable;
      chord_en_q <= chord_enable;
      chord_q    <= chord_button;
      lo_q       <= range_low;
      hi_q       <= range_high;
      key_q      <= entry_key;
    end
  end

  // map tables
  assign btn_wr = '{button: num_q, chord_en: chord_en_q, chord: chord_q, key: key_q};
  assign ax_wr  = '{axis: num_q, lo: lo_q, hi: hi_q, key: key_q};

  jekm_ram #(
    .WIDTH ($bits(jekm_pkg::btn_entry_t)),
    .DEPTH (MAP_ENTRIES)
  ) u_btn_table (
    .clk   (clk),
    .we    (cmd.write_btn && slot_ok),
    .waddr (slot_sel),
    .wdata (btn_wr),
    .raddr (scan_idx),
    .rdata (btn_rdata)
  );

  jekm_ram #(
    .WIDTH ($bits(jekm_pkg::ax_entry_t)),
    .DEPTH (MAP_ENTRIES)
  ) u_ax_table (
    .clk   (clk),
    .we    (cmd.write_ax && slot_ok),
    .waddr (slot_sel),
    .wdata (ax_wr),
    .raddr (scan_idx),
    .rdata (ax_rdata)
  );

  // last axis positions, read at the event's axis
  jekm_ram #(
    .WIDTH (16),
    .DEPTH (MAX_AXES)
  ) u_ax_pos (
    .clk   (clk),
    .we    (cmd.ax_write),
    .waddr (ax_sel),
    .wdata (val_q),
    .raddr (ax_sel),
    .rdata (pos_rdata)
  );

  assign btn_rd  = jekm_pkg::btn_entry_t'(btn_rdata);
  assign ax_rd   = jekm_pkg::ax_entry_t'(ax_rdata);
  assign old_pos = pos_valid[ax_sel] ? pos_rdata : 16'sd0;

  // entry enables and position valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      btn_en    <= '0;
      ax_en     <= '0;
      pos_valid <= '0;
    end else begin
      if (cmd.write_btn && slot_ok) begin
        btn_en[slot_sel] <= en_q;
      end
      if (cmd.write_ax && slot_ok) begin
        ax_en[slot_sel] <= en_q;
      end
      if (cmd.ax_write) begin
        pos_valid[ax_sel] <= 1'b1;
      end
    end
  end

  // scan address and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      issued_all <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      issued_all <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.issue) begin
        scan_idx <= EW'(scan_idx + 1'b1);
        if (scan_idx == LAST_IDX) begin
          issued_all <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx <= scan_idx;
    end
  end

  // entry match logic
  assign btn_base    = rd_valid && btn_en[rd_idx] && (btn_rd.button == num_q);
  assign chord_held  = (NW'(btn_rd.chord) < NW'(buttons_in_use)) &&
                       (NW'(btn_rd.chord) < NW'(MAX_BUTTONS)) &&
                       button_pressed[btn_rd.chord[BW-1:0]];
  assign chord_match = btn_base && btn_rd.chord_en && chord_held;
  assign plain_match = btn_base && !btn_rd.chord_en;
  assign move_match  = rd_valid && ax_en[rd_idx] && (ax_rd.axis == num_q) &&
                       ((old_pos < ax_rd.lo) || (old_pos > ax_rd.hi)) &&
                       (val_q >= ax_rd.lo) && (val_q <= ax_rd.hi);

  assign hit_take = (hit_count < jekm_pkg::RESULT_CNT_W'(jekm_pkg::RESULT_LIMIT)) &&
                    ((cmd.eval_chord && chord_match) ||
                     (cmd.eval_plain && plain_match) ||
                     (cmd.eval_move && move_match));
  assign new_key  = cmd.eval_move ? ax_rd.key : btn_rd.key;

  // pressed bits
  always_ff @(posedge clk) begin
    if (rst) begin
      button_pressed <= '0;
    end else begin
      if (cmd.eval_chord && chord_match) begin
        button_pressed[btn_rd.chord[BW-1:0]] <= 1'b0;
      end
      if (cmd.btn_update) begin
        button_pressed[btn_sel] <= (val_q == 16'sd1);
      end
    end
  end

  // result control: one hit held back so the final one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      hit_count  <= '0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load) begin
        hit_count <= '0;
      end
      if (hit_take) begin
        strobe     <= pend_valid;
        pend_valid <= 1'b1;
        hit_count  <= jekm_pkg::RESULT_CNT_W'(hit_count + 1'b1);
      end
      if (cmd.flush) begin
        strobe     <= pend_valid;
        pend_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (hit_take) begin
      key_code    <= pend_key;
      hit_entry   <= pend_idx;
      hit_is_axis <= pend_axis;
      last_key    <= 1'b0;
      pend_key    <= new_key;
      pend_idx    <= 4'(rd_idx);
      pend_axis   <= cmd.eval_move;
    end
    if (cmd.flush) begin
      key_code    <= pend_key;
      hit_entry   <= pend_idx;
      hit_is_axis <= pend_axis;
      last_key    <= 1'b1;
    end
  end

  // status to the controller
  assign st.req_type     = req_q;
  assign st.ev_init      = init_q;
  assign st.ev_axis      = axis_q;
  assign st.in_range     = axis_q ? num_in_axes : num_in_buttons;
  assign st.release_cond = !init_q && (val_q == 16'sd0) && button_pressed[btn_sel];
  assign st.chord_hit    = chord_match;
  assign st.issued_all   = issued_all;
  assign st.rd_valid     = rd_valid;

endmodule

`default_nettype wire

FILE: src/joystick_event_key_mapper_unit.sv
// channel   direction  signals                                         beat
// --------  ---------  ----------------------------------------------  -------------------
// command   in         start, busy, req_type .. entry_key              start && !busy
// result    out        strobe, key_code, hit_entry, hit_is_axis,       strobe, one cycle
//                      last_key
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//
// table writes, ignored events, axis init events and non-release button events end in decode
// axis moves and button releases scan the map table, one entry per cycle, through its
// single read port; a button release scans it twice when no chord entry hits
// results come out during the scan, the last one flagged in the same cycle that busy drops
// reset clears the count registers, pressed bits, axis positions (valid bits) and table enables
// results cannot be held off; cfg_ready is always high
`default_nettype none

module joystick_event_key_mapper_unit #(
  parameter int unsigned MAX_BUTTONS = 32,
  parameter int unsigned MAX_AXES    = 8,
  parameter int unsigned MAP_ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       req_type,
  input  wire logic                             event_init,
  input  wire logic                             event_axis,
  input  wire logic [7:0]                       control_number,
  input  wire logic signed [15:0]               control_value,
  input  wire logic [3:0]                       entry_index,
  input  wire logic                             entry_enable,
  input  wire logic                             chord_enable,
  input  wire logic [7:0]                       chord_button,
  input  wire logic signed [15:0]               range_low,
  input  wire logic signed [15:0]               range_high,
  input  wire logic [7:0]                       entry_key,
  output logic                                  strobe,
  output logic [7:0]                            key_code,
  output logic [3:0]                            hit_entry,
  output logic                                  hit_is_axis,
  output logic                                  last_key,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [jekm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [jekm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  jekm_pkg::ctrl_cmd_t    cmd;
  jekm_pkg::ctrl_status_t st;

  assign cfg_ready = 1'b1;

  jekm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  jekm_dpath #(
    .MAX_BUTTONS (MAX_BUTTONS),
    .MAX_AXES    (MAX_AXES),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .event_init     (event_init),
    .event_axis     (event_axis),
    .control_number (control_number),
    .control_value  (control_value),
    .entry_index    (entry_index),
    .entry_enable   (entry_enable),
    .chord_enable   (chord_enable),
    .chord_button   (chord_button),
    .range_low      (range_low),
    .range_high     (range_high),
    .entry_key      (entry_key),
    .strobe         (strobe),
    .key_code       (key_code),
    .hit_entry      (hit_entry),
    .hit_is_axis    (hit_is_axis),
    .last_key       (last_key)
  );

  // an accepted command always raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // results only appear while or right after the block works
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without a command in progress");

  // a result that is not the last leaves the event in progress
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_key) |-> busy)
    else $error("non-final result but block went idle");

  // nothing follows the final result of an event in the next cycle
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_key) |=> !strobe)
    else $error("result beat right after the final one");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_BUTTONS     = 32;
  localparam int N_AXES        = 8;
  localparam int N_ENTRIES     = 16;
  // longest scan is a button release: two passes over the table plus overhead
  localparam int SETTLE_CYCLES = 2 * N_ENTRIES + 8;
  localparam bit [1:0] REQ_RESERVED = 2'd3;

  // one request as the sender sees it
  typedef struct {
    bit [1:0]         req;
    bit               init;
    bit               is_axis;
    bit [7:0]         num;
    bit signed [15:0] val;
    bit [3:0]         slot;
    bit               en;
    bit               chord_en;
    bit [7:0]         chord;
    bit signed [15:0] lo;
    bit signed [15:0] hi;
    bit [7:0]         key;
  } map_cmd_t;

  // one emitted key
  typedef struct {
    bit [7:0] key;
    bit [3:0] entry;
    bit       is_axis;
    bit       last;
  } key_hit_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [1:0]                       req_type = '0;
  logic                             event_init = 1'b0;
  logic                             event_axis = 1'b0;
  logic [7:0]                       control_number = '0;
  logic signed [15:0]               control_value = '0;
  logic [3:0]                       entry_index = '0;
  logic                             entry_enable = 1'b0;
  logic                             chord_enable = 1'b0;
  logic [7:0]                       chord_button = '0;
  logic signed [15:0]               range_low = '0;
  logic signed [15:0]               range_high = '0;
  logic [7:0]                       entry_key = '0;
  logic                             strobe;
  logic [7:0]                       key_code;
  logic [3:0]                       hit_entry;
  logic                             hit_is_axis;
  logic                             last_key;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [jekm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [jekm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // mirror of the block state
  bit [5:0]             btn_count_reg;
  bit [3:0]             axis_count_reg;
  bit                   btn_held[N_BUTTONS];
  bit signed [15:0]     axis_pos[N_AXES];
  bit                   btn_en[N_ENTRIES];
  jekm_pkg::btn_entry_t btn_map[N_ENTRIES];
  bit                   ax_en[N_ENTRIES];
  jekm_pkg::ax_entry_t  ax_map[N_ENTRIES];

  key_hit_t pending_keys[$];
  int       errors;
  int       burst_left;

  joystick_event_key_mapper_unit i_dut (.*);

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // keys expected from one accepted request, state updated along the way
  task automatic predict_keys(input map_cmd_t c);
    key_hit_t hits[$];
    int eff_b;
    int eff_a;
    int old_v;
    int new_v;
    int lo_v;
    int hi_v;
    bit chord_done;
    eff_b = (btn_count_reg < N_BUTTONS) ? btn_count_reg : N_BUTTONS;
    eff_a = (axis_count_reg < N_AXES) ? axis_count_reg : N_AXES;
    case (c.req)
      jekm_pkg::REQ_BTN_WRITE: begin
        btn_en[c.slot] = c.en;
        btn_map[c.slot] = '{button: c.num, chord_en: c.chord_en, chord: c.chord, key: c.key};
      end
      jekm_pkg::REQ_AX_WRITE: begin
        ax_en[c.slot] = c.en;
        ax_map[c.slot] = '{axis: c.num, lo: c.lo, hi: c.hi, key: c.key};
      end
      jekm_pkg::REQ_EVENT: begin
        if (!c.is_axis && c.num < eff_b) begin
          // release from pressed: first held chord wins, else all plain entries
          if (!c.init && c.val == 0 && btn_held[c.num]) begin
            chord_done = 1'b0;
            for (int i = 0; i < N_ENTRIES; i++) begin
              if (!chord_done && btn_en[i] && btn_map[i].button == c.num &&
                  btn_map[i].chord_en && btn_map[i].chord < eff_b &&
                  btn_held[btn_map[i].chord]) begin
                hits.push_back('{btn_map[i].key, 4'(i), 1'b0, 1'b0});
                btn_held[btn_map[i].chord] = 1'b0;
                chord_done = 1'b1;
              end
            end
            if (!chord_done) begin
              for (int i = 0; i < N_ENTRIES; i++) begin
                if (btn_en[i] && btn_map[i].button == c.num && !btn_map[i].chord_en)
                  hits.push_back('{btn_map[i].key, 4'(i), 1'b0, 1'b0});
              end
            end
          end
          btn_held[c.num] = (c.val == 1);
        end else if (c.is_axis && c.num < eff_a) begin
          // axis move: entries whose range is entered from outside
          if (!c.init) begin
            old_v = axis_pos[c.num];
            new_v = c.val;
            for (int i = 0; i < N_ENTRIES; i++) begin
              lo_v = $signed(ax_map[i].lo);
              hi_v = $signed(ax_map[i].hi);
              if (ax_en[i] && ax_map[i].axis == c.num && (old_v < lo_v || old_v > hi_v) &&
                  new_v >= lo_v && new_v <= hi_v)
                hits.push_back('{ax_map[i].key, 4'(i), 1'b1, 1'b0});
            end
          end
          axis_pos[c.num] = c.val;
        end
      end
      default: ;
    endcase
    if (hits.size() > 0)
      hits[hits.size() - 1].last = 1'b1;
    foreach (hits[k])
      pending_keys.push_back(hits[k]);
  endtask

  // send one request beat, then maybe pause between bursts
  task automatic issue_request(input map_cmd_t c);
    int gap;
    start          <= 1'b1;
    req_type       <= c.req;
    event_init     <= c.init;
    event_axis     <= c.is_axis;
    control_number <= c.num;
    control_value  <= c.val;
    entry_index    <= c.slot;
    entry_enable   <= c.en;
    chord_enable   <= c.chord_en;
    chord_button   <= c.chord;
    range_low      <= c.lo;
    range_high     <= c.hi;
    entry_key      <= c.key;
    do @(posedge clk); while (busy);
    predict_keys(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 8);
      case ($urandom_range(3))
        0: gap = 0;
        1: gap = $urandom_range(1, 45);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and let every expected key come out
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // write both count registers, back to back beats
  task automatic set_counts(input bit [5:0] nb, input bit [5:0] na);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= jekm_pkg::CFG_BUTTONS_IN_USE;
    cfg_data  <= nb;
    do @(posedge clk); while (!cfg_ready);
    btn_count_reg = nb;
    cfg_index <= jekm_pkg::CFG_AXES_IN_USE;
    cfg_data  <= na;
    do @(posedge clk); while (!cfg_ready);
    axis_count_reg = na[3:0];
    cfg_valid <= 1'b0;
  endtask

  function automatic map_cmd_t btn_write(input bit [3:0] slot, input bit [7:0] num,
                                         input bit en, input bit chord_en,
                                         input bit [7:0] chord, input bit [7:0] key);
    map_cmd_t c;
    c = '{default: 0};
    c.req = jekm_pkg::REQ_BTN_WRITE;
    c.slot = slot;
    c.num = num;
    c.en = en;
    c.chord_en = chord_en;
    c.chord = chord;
    c.key = key;
    return c;
  endfunction

  function automatic map_cmd_t ax_write(input bit [3:0] slot, input bit [7:0] num,
                                        input bit signed [15:0] lo,
                                        input bit signed [15:0] hi, input bit [7:0] key);
    map_cmd_t c;
    c = '{default: 0};
    c.req = jekm_pkg::REQ_AX_WRITE;
    c.slot = slot;
    c.num = num;
    c.en = 1'b1;
    c.lo = lo;
    c.hi = hi;
    c.key = key;
    return c;
  endfunction

  function automatic map_cmd_t joy_event(input bit is_axis, input bit init,
                                         input bit [7:0] num, input bit signed [15:0] val);
    map_cmd_t c;
    c = '{default: 0};
    c.req = jekm_pkg::REQ_EVENT;
    c.is_axis = is_axis;
    c.init = init;
    c.num = num;
    c.val = val;
    return c;
  endfunction

  // mostly low control numbers so that events hit the table entries
  function automatic bit [7:0] pick_number(input int count, input int span);
    if (count == 0 || $urandom_range(9) == 0)
      return 8'($urandom);
    return 8'($urandom_range(0, (count - 1 < span) ? count - 1 : span));
  endfunction

  // counts are zero after reset: events ignored, writes and unknown requests silent
  task automatic test_ignored_events();
    map_cmd_t c;
    issue_request(btn_write(4'd0, 8'd0, 1'b1, 1'b0, 8'd0, 8'h11));
    issue_request(joy_event(1'b0, 1'b0, 8'd255, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd0, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd0, 16'sd0));
    c = joy_event(1'b1, 1'b0, 8'd0, 16'sd5);
    c.req = REQ_RESERVED;
    issue_request(c);
  endtask

  // plain entries on release, negative value, init press, disabled entry
  task automatic test_plain_release();
    issue_request(btn_write(4'd0, 8'd31, 1'b1, 1'b0, 8'd0, 8'h00));
    issue_request(btn_write(4'd15, 8'd31, 1'b1, 1'b0, 8'd0, 8'hFF));
    issue_request(btn_write(4'd1, 8'd31, 1'b0, 1'b0, 8'd0, 8'h33));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd0));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, -16'sd32768));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd0));
    issue_request(joy_event(1'b0, 1'b1, 8'd31, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd0));
  endtask

  // held chord wins once and is cleared; out of range chord never held
  task automatic test_chord_release();
    issue_request(btn_write(4'd3, 8'd31, 1'b1, 1'b1, 8'd30, 8'h5A));
    issue_request(btn_write(4'd4, 8'd31, 1'b1, 1'b1, 8'd200, 8'h77));
    issue_request(joy_event(1'b0, 1'b0, 8'd30, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd0));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd1));
    issue_request(joy_event(1'b0, 1'b0, 8'd31, 16'sd0));
  endtask

  // range entry at the negative extreme, empty range, init move
  task automatic test_axis_ranges();
    issue_request(ax_write(4'd2, 8'd7, -16'sd32768, -16'sd100, 8'h81));
    issue_request(ax_write(4'd9, 8'd7, 16'sd100, 16'sd50, 8'h42));
    issue_request(joy_event(1'b1, 1'b0, 8'd7, -16'sd32768));
    issue_request(joy_event(1'b1, 1'b1, 8'd7, 16'sd75));
    issue_request(joy_event(1'b1, 1'b0, 8'd7, -16'sd200));
    issue_request(joy_event(1'b1, 1'b0, 8'd7, 16'sd32767));
  endtask

  // random table writes and events under one pair of counts
  task automatic test_random_traffic(input bit [5:0] nb_raw, input bit [5:0] na_raw,
                                     input int n_items);
    map_cmd_t c;
    int nb;
    int na;
    int pick;
    int sel;
    bit signed [15:0] swap_val;
    bit signed [15:0] bound_val;
    set_counts(nb_raw, na_raw);
    nb = (nb_raw > N_BUTTONS) ? N_BUTTONS : nb_raw;
    na = (na_raw[3:0] > N_AXES) ? N_AXES : na_raw[3:0];
    repeat (n_items) begin
      c.req = jekm_pkg::REQ_EVENT;
      c.init = ($urandom_range(9) == 0);
      c.is_axis = 1'b0;
      c.num = 8'($urandom);
      c.val = 16'($urandom);
      c.slot = 4'($urandom);
      c.en = ($urandom_range(9) != 0);
      c.chord_en = ($urandom_range(4) < 2);
      c.chord = 8'($urandom);
      c.lo = 16'($urandom);
      c.hi = 16'($urandom);
      c.key = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 12) begin
        c.req = jekm_pkg::REQ_BTN_WRITE;
        c.num = pick_number(nb, 5);
        if ($urandom_range(9) != 0)
          c.chord = pick_number(nb, 5);
      end else if (pick < 20) begin
        c.req = jekm_pkg::REQ_AX_WRITE;
        c.num = pick_number(na, 2);
        if (c.lo > c.hi && $urandom_range(9) != 0) begin
          swap_val = c.lo;
          c.lo = c.hi;
          c.hi = swap_val;
        end
      end else if (pick < 22) begin
        c.req = REQ_RESERVED;
      end else if (pick < 62) begin
        c.num = pick_number(nb, 5);
        sel = $urandom_range(19);
        if (sel < 9)
          c.val = 16'sd1;
        else if (sel < 18)
          c.val = 16'sd0;
      end else begin
        c.is_axis = 1'b1;
        c.num = pick_number(na, 2);
        // land on or next to a range bound about half the time
        sel = $urandom_range(15);
        if ($urandom_range(1) == 1 && ax_en[sel]) begin
          bound_val = $urandom_range(1) ? ax_map[sel].lo : ax_map[sel].hi;
          c.val = bound_val + 16'($urandom_range(2)) - 16'sd1;
        end
      end
      issue_request(c);
    end
  endtask

  // compare each key beat with the oldest expected key
  always @(posedge clk) begin : check_keys
    key_hit_t want;
    if (!rst && strobe) begin
      if (pending_keys.size() == 0) begin
        $error("unexpected key: key_code %0d hit_entry %0d hit_is_axis %0d last_key %0d",
               key_code, hit_entry, hit_is_axis, last_key);
        errors++;
      end else begin
        want = pending_keys.pop_front();
        if (key_code !== want.key) begin
          $error("key_code: expected %0d, got %0d", want.key, key_code);
          errors++;
        end
        if (hit_entry !== want.entry) begin
          $error("hit_entry: expected %0d, got %0d", want.entry, hit_entry);
          errors++;
        end
        if (hit_is_axis !== want.is_axis) begin
          $error("hit_is_axis: expected %0d, got %0d", want.is_axis, hit_is_axis);
          errors++;
        end
        if (last_key !== want.last) begin
          $error("last_key: expected %0d, got %0d", want.last, last_key);
          errors++;
        end
      end
    end
  end

  // test sequence
  initial begin
    errors = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ignored_events();
    set_counts(6'd63, 6'd15);
    test_plain_release();
    test_chord_release();
    test_axis_ranges();
    test_random_traffic(6'd32, 6'd8, 70);
    test_random_traffic(6'($urandom_range(2, 12)), {2'($urandom), 4'($urandom_range(1, 4))},
                        70);
    test_random_traffic(6'd63, 6'd15, 65);
    test_random_traffic(6'd20, 6'd51, 65);
    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
